// File: hw/rtl/longest_valid_paren_span_core_defines.svh
// assertion macros shared by the rtl files
// clocked on clk_i and disabled while rst_ni is low
`ifndef LONGEST_VALID_PAREN_SPAN_CORE_DEFINES_SVH
`define LONGEST_VALID_PAREN_SPAN_CORE_DEFINES_SVH

`ifndef SYNTH

// property that must hold at every edge
`define LVPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lvps assertion failed");

// consequent that must hold in the cycle after the antecedent
`define LVPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lvps assertion failed");

`else

`define LVPS_ASSERT(lbl, prop)
`define LVPS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/lvps_pkg.sv
package lvps_pkg;

  // longest string that is fully evaluated
  localparam int unsigned MaxLen     = 4096;
  // base marker plus one entry per character
  localparam int unsigned StackDepth = MaxLen + 1;
  // stored positions run from 0 (base marker) up to MaxLen
  localparam int unsigned PosW       = $clog2(MaxLen + 1);
  // entry count runs from 1 up to StackDepth
  localparam int unsigned CntW       = $clog2(StackDepth + 1);
  // the top entry lives in a register, the rest in ram
  localparam int unsigned RamDepth   = StackDepth - 1;
  localparam int unsigned RamAw      = $clog2(RamDepth);

  localparam int unsigned CharW      = 8;
  localparam int unsigned SpanW      = 13;

  localparam logic [CharW-1:0] OpenCode = CharW'(40);

  // request from the scan logic to the position stack
  typedef struct packed {
    logic            push;
    logic            pop;
    logic            clear;
    logic [PosW-1:0] value;
  } stk_cmd_t;

  // view of the stack ahead of the next request
  typedef struct packed {
    logic            base_only;
    logic [PosW-1:0] below;
  } stk_stat_t;

endpackage

// File: hw/rtl/lvps_char_if.sv
interface lvps_char_if;
  logic                             valid;
  logic                             ready;
  logic [lvps_pkg::CharW-1:0]       char_code;
  logic                             is_final;

  modport source (output valid, output char_code, output is_final, input ready);
  modport sink   (input valid, input char_code, input is_final, output ready);
endinterface

// File: hw/rtl/lvps_res_if.sv
interface lvps_res_if;
  logic                             valid;
  logic                             ready;
  logic [lvps_pkg::SpanW-1:0]       longest_span;
  logic                             too_long;

  modport source (output valid, output longest_span, output too_long, input ready);
  modport sink   (input valid, input longest_span, input too_long, output ready);
endinterface

// File: hw/rtl/longest_valid_paren_span_core.sv
// channel  dir  modport  payload                      transaction
// chr_i    in   sink     char_code[7:0], is_final     valid & ready
// res_o    out  source   longest_span[12:0], too_long valid & ready
//
// one character per cycle while chr_i.ready is high; the stack ram is read ahead
// result appears on res_o the cycle after the final character is taken
// chr_i.ready is low only while a result waits and res_o.ready is low
// reset is asynchronous, active low; no ram clearing pass is needed after reset
// more than 4096 characters only sets too_long; extra characters are ignored
`include "longest_valid_paren_span_core_defines.svh"

module longest_valid_paren_span_core (
  input  logic clk_i,
  input  logic rst_ni,
  lvps_char_if.sink  chr_i,
  lvps_res_if.source res_o
);

  logic [lvps_pkg::PosW-1:0]  pos_q, pos_d;
  logic [lvps_pkg::PosW-1:0]  best_q, best_d;
  logic                       ovf_q, ovf_d;
  logic                       out_vld_q, out_vld_d;
  logic [lvps_pkg::SpanW-1:0] out_span_q;
  logic                       out_tl_q;

  logic                       take;
  logic                       proc;
  logic                       is_open;
  logic [lvps_pkg::PosW-1:0]  here;
  logic [lvps_pkg::PosW-1:0]  len;
  logic                       last_take;
  lvps_pkg::stk_cmd_t         cmd;
  lvps_pkg::stk_stat_t        stat;

  // input side stalls only on a full output register
  assign chr_i.ready = !out_vld_q || res_o.ready;
  assign take        = chr_i.valid && chr_i.ready;
  assign last_take   = take && chr_i.is_final;
  assign proc        = take && (pos_q < lvps_pkg::PosW'(lvps_pkg::MaxLen));
  assign is_open     = (chr_i.char_code == lvps_pkg::OpenCode);
  assign here        = pos_q + lvps_pkg::PosW'(1);

  // stack request
  always_comb begin
    cmd.push  = proc && is_open;
    cmd.pop   = proc && !is_open;
    cmd.clear = last_take;
    cmd.value = here;
  end

  lvps_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  // span closed by this character
  assign len = (here >= stat.below) ? (here - stat.below) : '0;

  // scan state update
  always_comb begin
    best_d = best_q;
    pos_d  = pos_q;
    ovf_d  = ovf_q;
    if (proc) begin
      pos_d = here;
      if (!is_open && !stat.base_only && (len > best_q)) begin
        best_d = len;
      end
    end else if (take) begin
      ovf_d = 1'b1;
    end
  end

  // output register handshake
  always_comb begin
    out_vld_d = out_vld_q;
    if (last_take) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      best_q    <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (last_take) begin
        pos_q  <= '0;
        best_q <= '0;
        ovf_q  <= 1'b0;
      end else begin
        pos_q  <= pos_d;
        best_q <= best_d;
        ovf_q  <= ovf_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (last_take) begin
      out_span_q <= lvps_pkg::SpanW'(best_d);
      out_tl_q   <= ovf_d;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.longest_span = out_span_q;
  assign res_o.too_long     = out_tl_q;

  `LVPS_ASSERT(a_ovf_at_limit, !ovf_q || pos_q == lvps_pkg::PosW'(lvps_pkg::MaxLen))
  `LVPS_ASSERT(a_best_bounded, best_q <= pos_q)
  `LVPS_ASSERT_NEXT(a_final_clears, last_take, pos_q == '0 && best_q == '0 && !ovf_q)

endmodule

// File: hw/rtl/lvps_ram.sv
module lvps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lvps_stack.sv
`include "longest_valid_paren_span_core_defines.svh"

module lvps_stack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lvps_pkg::stk_cmd_t  cmd_i,
  output lvps_pkg::stk_stat_t stat_o
);

  logic [lvps_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [lvps_pkg::PosW-1:0]  top_q, top_d;
  logic                       fwd_q, fwd_d;
  logic [lvps_pkg::PosW-1:0]  fwd_val_q, fwd_val_d;

  logic                       ram_we;
  logic                       ram_re;
  logic [lvps_pkg::CntW-1:0]  wr_idx;
  logic [lvps_pkg::CntW-1:0]  rd_idx;
  logic [lvps_pkg::PosW-1:0]  ram_rdata;
  logic [lvps_pkg::PosW-1:0]  below;
  logic                       can_push;

  // ram holds entries 0 .. cnt-2, the top entry sits in top_q
  assign wr_idx   = cnt_q - lvps_pkg::CntW'(1);
  assign rd_idx   = cnt_q - lvps_pkg::CntW'(3);
  assign can_push = cnt_q < lvps_pkg::CntW'(lvps_pkg::StackDepth);

  // entry below the top: forwarded after a push, else from the prefetch read
  assign below = fwd_q ? fwd_val_q : ram_rdata;

  assign stat_o.base_only = (cnt_q == lvps_pkg::CntW'(1));
  assign stat_o.below     = below;

  // push spills the old top to ram, pop pulls the next-below entry ahead of time; popping the base marker replaces it
  always_comb begin
    cnt_d     = cnt_q;
    top_d     = top_q;
    fwd_d     = fwd_q;
    fwd_val_d = fwd_val_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    if (cmd_i.push && can_push) begin
      ram_we    = 1'b1;
      top_d     = cmd_i.value;
      cnt_d     = cnt_q + lvps_pkg::CntW'(1);
      fwd_d     = 1'b1;
      fwd_val_d = top_q;
    end else if (cmd_i.pop) begin
      if (cnt_q == lvps_pkg::CntW'(1)) begin
        // popped the base marker: this position becomes the new base
        top_d = cmd_i.value;
      end else begin
        top_d = below;
        cnt_d = cnt_q - lvps_pkg::CntW'(1);
        if (cnt_q >= lvps_pkg::CntW'(3)) begin
          ram_re = 1'b1;
          fwd_d  = 1'b0;
        end
      end
    end
    if (cmd_i.clear) begin
      cnt_d = lvps_pkg::CntW'(1);
      top_d = '0;
      fwd_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= lvps_pkg::CntW'(1);
      top_q <= '0;
      fwd_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      top_q <= top_d;
      fwd_q <= fwd_d;
    end
  end

  // forwarded value
  always_ff @(posedge clk_i) begin
    fwd_val_q <= fwd_val_d;
  end

  lvps_ram #(
    .Width (lvps_pkg::PosW),
    .Depth (lvps_pkg::RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx[lvps_pkg::RamAw-1:0]),
    .wdata_i (top_q),
    .re_i    (ram_re),
    .raddr_i (rd_idx[lvps_pkg::RamAw-1:0]),
    .rdata_o (ram_rdata)
  );

  `LVPS_ASSERT(a_cnt_nonzero, cnt_q != '0)
  `LVPS_ASSERT(a_push_room, !cmd_i.push || can_push)
  `LVPS_ASSERT_NEXT(a_clear_base, cmd_i.clear, cnt_q == lvps_pkg::CntW'(1) && top_q == '0)

endmodule
